// File: hdl/irpd_pkg.sv
// Shared types, constants and helpers of the IR remote pulse decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package irpd_pkg;

    // Frame buffer capacity
    localparam int FRAME_CAPACITY_DEF = 128;

    // Field widths
    localparam int DUR_W    = 20;
    localparam int VAL_W    = 16;
    localparam int MINP_W   = 8;
    localparam int PCNT_W   = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [VAL_W-1:0] VAL_MAX = '1;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAP_LIMIT  = 1'b0,
        CFG_MIN_PULSES = 1'b1
    } cfg_index_t;

    localparam logic [DUR_W-1:0]  GAP_LIMIT_RST  = 20'd100000;
    localparam logic [MINP_W-1:0] MIN_PULSES_RST = 8'd10;

    // Protocol codes
    typedef enum logic [1:0] {
        PROTO_NEC  = 2'd0,
        PROTO_SONY = 2'd1,
        PROTO_RC5  = 2'd2
    } proto_t;

    // Header windows
    localparam logic [VAL_W-1:0] NEC_HDR_MARK_LO  = 16'd8000;
    localparam logic [VAL_W-1:0] NEC_HDR_MARK_HI  = 16'd10000;
    localparam logic [VAL_W-1:0] NEC_HDR_SPACE_LO = 16'd4000;
    localparam logic [VAL_W-1:0] NEC_HDR_SPACE_HI = 16'd5000;
    localparam logic [VAL_W-1:0] SONY_HDR_MARK_LO  = 16'd2000;
    localparam logic [VAL_W-1:0] SONY_HDR_MARK_HI  = 16'd2800;
    localparam logic [VAL_W-1:0] SONY_HDR_SPACE_LO = 16'd400;
    localparam logic [VAL_W-1:0] SONY_HDR_SPACE_HI = 16'd800;
    localparam logic [VAL_W-1:0] RC5_LO = 16'd700;
    localparam logic [VAL_W-1:0] RC5_HI = 16'd1000;

    // Data pair windows
    localparam logic [VAL_W-1:0] NEC_MARK_LO    = 16'd500;
    localparam logic [VAL_W-1:0] NEC_MARK_HI    = 16'd700;
    localparam logic [VAL_W-1:0] NEC_ONE_SPACE  = 16'd1600;
    localparam logic [VAL_W-1:0] NEC_ZERO_SPACE = 16'd500;
    localparam logic [VAL_W-1:0] SONY_MARK_LO    = 16'd1000;
    localparam logic [VAL_W-1:0] SONY_MARK_HI    = 16'd1400;
    localparam logic [VAL_W-1:0] SONY_ONE_SPACE  = 16'd1200;
    localparam logic [VAL_W-1:0] SONY_ZERO_SPACE = 16'd400;
    localparam logic [VAL_W-1:0] RC5_ONE_MARK    = 16'd800;

    // Minimum frame lengths
    localparam int NEC_MIN_LEN  = 68;
    localparam int SONY_MIN_LEN = 24;
    localparam int RC5_MIN_LEN  = 28;

    // Code register widths
    localparam int NEC_BITS_W  = 32;
    localparam int SONY_BITS_W = 16;
    localparam int RC5_BITS_W  = 11;

    // One classified duration travelling from front to back
    typedef struct packed {
        logic             is_gap;
        logic [VAL_W-1:0] value;
    } irpd_entry_t;

    // One result item
    typedef struct packed {
        logic              decoded;
        logic [1:0]        protocol;
        logic [15:0]       address;
        logic [15:0]       command;
        logic              repeat_res;
        logic [PCNT_W-1:0] pulse_count;
    } irpd_result_t;

    function automatic logic in_window(
        input logic [VAL_W-1:0] v,
        input logic [VAL_W-1:0] lo,
        input logic [VAL_W-1:0] hi
    );
        return (v >= lo) && (v <= hi);
    endfunction

endpackage

`default_nettype wire

// File: hdl/ir_remote_pulse_decoder_top.sv
// Top level of the IR remote pulse decoder: configuration registers and wiring.
// Depends on irpd_pkg, irpd_front, irpd_queue and irpd_back.
`default_nettype none

// Channel   Signals                                  Handshake
// -------   --------------------------------------   ---------------------
// input     duration_us                              in_valid / in_ready
// output    decoded protocol address command         out_valid / out_ready
//           repeat_res pulse_count
// config    cfg_index cfg_wdata                      cfg_we (no wait)
//
// One duration per cycle sustained while out_ready stays high; a result is presented
// after its input transfer passes through the queue (entry written on transfer)
// and then the checker update registered into the result register.
// The back end takes one queue entry per cycle while out_ready is high, so the front never fills the
// two-entry queue unless out_ready is held low.
// Reset clears the frame state, the queue and the output valid flag, and loads
// gap limit 100000 us and minimum pulse count 10. No clearing pass is needed.
// While out_ready is low the result register holds, the queue fills, then
// in_ready drops.

module ir_remote_pulse_decoder_top #(
    parameter int FRAME_CAPACITY = irpd_pkg::FRAME_CAPACITY_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input channel
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [irpd_pkg::DUR_W-1:0]      duration_us,
    // output channel
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 decoded,
    output logic [1:0]                           protocol,
    output logic [15:0]                          address,
    output logic [15:0]                          command,
    output logic                                 repeat_res,
    output logic [irpd_pkg::PCNT_W-1:0]          pulse_count,
    // configuration port
    input  wire logic                            cfg_we,
    input  wire logic [irpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [irpd_pkg::DUR_W-1:0]      cfg_wdata
);
    import irpd_pkg::*;

    logic [DUR_W-1:0]  gap_limit_reg;
    logic [MINP_W-1:0] min_pulses_reg;

    logic         push;
    irpd_entry_t  push_entry;
    logic         q_full;
    logic         q_valid;
    irpd_entry_t  q_head;
    logic         pop;
    irpd_result_t result;

    // Configuration registers: the user must write them only while the block is idle; the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_limit_reg  <= GAP_LIMIT_RST;
            min_pulses_reg <= MIN_PULSES_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_GAP_LIMIT:  gap_limit_reg  <= cfg_wdata;
                CFG_MIN_PULSES: min_pulses_reg <= cfg_wdata[MINP_W-1:0];
            endcase
        end
    end

    // Front: classify each transfer as gap or stored duration
    irpd_front u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .duration_us (duration_us),
        .gap_limit   (gap_limit_reg),
        .q_full      (q_full),
        .push        (push),
        .entry       (push_entry)
    );

    // Decouple front and back so each side can stall on its own
    irpd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .not_empty  (q_valid),
        .head       (q_head)
    );

    // Back: advance the frame and the checkers, register the result
    irpd_back #(
        .FRAME_CAPACITY (FRAME_CAPACITY)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .pop        (pop),
        .min_pulses (min_pulses_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result)
    );

    // Unpack the result onto its own ports
    assign decoded     = result.decoded;
    assign protocol    = result.protocol;
    assign address     = result.address;
    assign command     = result.command;
    assign repeat_res  = result.repeat_res;
    assign pulse_count = result.pulse_count;

endmodule

`default_nettype wire

// File: hdl/irpd_front.sv
// Front end: accepts durations, flags gaps and saturates to 16 bits.
// Depends on irpd_pkg.
`default_nettype none

module irpd_front (
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [irpd_pkg::DUR_W-1:0]  duration_us,
    input  wire logic [irpd_pkg::DUR_W-1:0]  gap_limit,
    input  wire logic                        q_full,
    output logic                             push,
    output irpd_pkg::irpd_entry_t            entry
);
    import irpd_pkg::*;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        entry.is_gap = (duration_us > gap_limit);
        if (duration_us > DUR_W'(VAL_MAX))
        begin
            entry.value = VAL_MAX;
        end
        else
        begin
            entry.value = duration_us[VAL_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: hdl/irpd_queue.sv
// Short FIFO between front and back end of the decoder.
// Depends on irpd_pkg.
`default_nettype none

module irpd_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire irpd_pkg::irpd_entry_t push_entry,
    input  wire logic                  pop,
    output logic                       full,
    output logic                       not_empty,
    output irpd_pkg::irpd_entry_t      head
);
    import irpd_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    irpd_entry_t            mem [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push not counted");

endmodule

`default_nettype wire

// File: hdl/irpd_back.sv
// Back end: frame state, the three protocol checkers and the result register.
// Depends on irpd_pkg.
`default_nettype none

module irpd_back #(
    parameter int FRAME_CAPACITY = irpd_pkg::FRAME_CAPACITY_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_valid,
    input  wire irpd_pkg::irpd_entry_t        q_head,
    output logic                              pop,
    input  wire logic [irpd_pkg::MINP_W-1:0]  min_pulses,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output irpd_pkg::irpd_result_t            result
);
    import irpd_pkg::*;

    localparam int CNT_W = $clog2(FRAME_CAPACITY + 1);
    localparam int CMP_W = (CNT_W > MINP_W) ? CNT_W : MINP_W;

    logic [CNT_W-1:0]       count_reg, count_next;
    logic [VAL_W-1:0]       pend_reg, pend_next;
    logic                   nec_alive_reg, nec_alive_next;
    logic                   sony_alive_reg, sony_alive_next;
    logic                   rc5_alive_reg, rc5_alive_next;
    logic [NEC_BITS_W-1:0]  nec_bits_reg, nec_bits_next;
    logic [SONY_BITS_W-1:0] sony_bits_reg, sony_bits_next;
    logic [RC5_BITS_W-1:0]  rc5_bits_reg, rc5_bits_next;
    logic                   out_valid_reg;
    irpd_result_t           result_reg, result_next;
    logic [VAL_W-1:0]       m, s;
    logic                   min_ok;

    // Take an entry whenever the output register is free or being drained
    assign pop       = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign m         = pend_reg;
    assign s         = q_head.value;

    always_comb
    begin
        count_next      = count_reg;
        pend_next       = pend_reg;
        nec_alive_next  = nec_alive_reg;
        sony_alive_next = sony_alive_reg;
        rc5_alive_next  = rc5_alive_reg;
        nec_bits_next   = nec_bits_reg;
        sony_bits_next  = sony_bits_reg;
        rc5_bits_next   = rc5_bits_reg;
        if (pop)
        begin
            if (q_head.is_gap)
            begin
                count_next      = '0;
                pend_next       = '0;
                nec_alive_next  = 1'b1;
                sony_alive_next = 1'b1;
                rc5_alive_next  = 1'b1;
                nec_bits_next   = '0;
                sony_bits_next  = '0;
                rc5_bits_next   = '0;
            end
            else if (count_reg < CNT_W'(FRAME_CAPACITY))
            begin
                if (count_reg[0])
                begin
                    if (count_reg == CNT_W'(1))
                    begin
                        nec_alive_next = nec_alive_reg
                            && in_window(m, NEC_HDR_MARK_LO, NEC_HDR_MARK_HI)
                            && in_window(s, NEC_HDR_SPACE_LO, NEC_HDR_SPACE_HI);
                        sony_alive_next = sony_alive_reg
                            && in_window(m, SONY_HDR_MARK_LO, SONY_HDR_MARK_HI)
                            && in_window(s, SONY_HDR_SPACE_LO, SONY_HDR_SPACE_HI);
                        rc5_alive_next = rc5_alive_reg
                            && in_window(m, RC5_LO, RC5_HI)
                            && in_window(s, RC5_LO, RC5_HI);
                    end
                    else
                    begin
                        if (nec_alive_reg)
                        begin
                            priority if (!in_window(m, NEC_MARK_LO, NEC_MARK_HI))
                                nec_alive_next = 1'b0;
                            else if (s > NEC_ONE_SPACE)
                                nec_bits_next = {nec_bits_reg[NEC_BITS_W-2:0], 1'b1};
                            else if (s > NEC_ZERO_SPACE)
                                nec_bits_next = {nec_bits_reg[NEC_BITS_W-2:0], 1'b0};
                            else
                                nec_alive_next = 1'b0;
                        end
                        if (sony_alive_reg)
                        begin
                            priority if (!in_window(m, SONY_MARK_LO, SONY_MARK_HI))
                                sony_alive_next = 1'b0;
                            else if (s > SONY_ONE_SPACE)
                                sony_bits_next = {sony_bits_reg[SONY_BITS_W-2:0], 1'b1};
                            else if (s > SONY_ZERO_SPACE)
                                sony_bits_next = {sony_bits_reg[SONY_BITS_W-2:0], 1'b0};
                            else
                                sony_alive_next = 1'b0;
                        end
                        if (rc5_alive_reg)
                        begin
                            if (!in_window(m, RC5_LO, RC5_HI) || !in_window(s, RC5_LO, RC5_HI))
                            begin
                                rc5_alive_next = 1'b0;
                            end
                            else
                            begin
                                rc5_bits_next = {rc5_bits_reg[RC5_BITS_W-2:0],
                                                 (m > RC5_ONE_MARK)};
                            end
                        end
                    end
                end
                else
                begin
                    pend_next = q_head.value;
                end
                count_next = count_reg + 1'b1;
            end
        end
    end

    // Result from the updated frame state
    always_comb
    begin
        min_ok = (CMP_W'(count_next) >= CMP_W'(min_pulses));
        result_next             = '0;
        result_next.pulse_count = PCNT_W'(count_next);
        priority if (min_ok && nec_alive_next && (count_next >= CNT_W'(NEC_MIN_LEN)))
        begin
            result_next.decoded    = 1'b1;
            result_next.protocol   = PROTO_NEC;
            result_next.address    = nec_bits_next[31:16];
            result_next.command    = nec_bits_next[15:0];
            result_next.repeat_res = (nec_bits_next == '1);
        end
        else if (min_ok && sony_alive_next && (count_next >= CNT_W'(SONY_MIN_LEN)))
        begin
            result_next.decoded  = 1'b1;
            result_next.protocol = PROTO_SONY;
            result_next.address  = {8'd0, sony_bits_next[15:8]};
            result_next.command  = {8'd0, sony_bits_next[7:0]};
        end
        else if (min_ok && rc5_alive_next && (count_next >= CNT_W'(RC5_MIN_LEN)))
        begin
            result_next.decoded  = 1'b1;
            result_next.protocol = PROTO_RC5;
            result_next.address  = {11'd0, rc5_bits_next[10:6]};
            result_next.command  = {10'd0, rc5_bits_next[5:0]};
        end
        else
        begin
            result_next.decoded = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            pend_reg       <= '0;
            nec_alive_reg  <= 1'b1;
            sony_alive_reg <= 1'b1;
            rc5_alive_reg  <= 1'b1;
            nec_bits_reg   <= '0;
            sony_bits_reg  <= '0;
            rc5_bits_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            pend_reg       <= pend_next;
            nec_alive_reg  <= nec_alive_next;
            sony_alive_reg <= sony_alive_next;
            rc5_alive_reg  <= rc5_alive_next;
            nec_bits_reg   <= nec_bits_next;
            sony_bits_reg  <= sony_bits_next;
            rc5_bits_reg   <= rc5_bits_next;
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FRAME_CAPACITY))
        else $error("frame count above capacity");

    a_gap_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_head.is_gap) |=>
            (out_valid_reg && !result_reg.decoded && (count_reg == '0)))
        else $error("gap did not restart the frame");

    a_repeat_nec_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.repeat_res) |->
            (result_reg.decoded && (result_reg.protocol == PROTO_NEC)))
        else $error("repeat flagged outside an NEC match");

    a_pop_holds_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !pop)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// File: tb/ir_remote_pulse_decoder_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for ir_remote_pulse_decoder_top: directed table, then random pulse trains.
// Depends on irpd_pkg and the decoder RTL; an in-bench frame predictor supplies expectations.

module ir_remote_pulse_decoder_top_tb;

    import irpd_pkg::*;

    localparam int FRAME_CAP = FRAME_CAPACITY_DEF;
    localparam logic [DUR_W-1:0] DUR_MAX = '1;
    localparam int DIR_ROWS = 28;

    // Shapes of random pulse train
    typedef enum int {
        TRAIN_NEC,
        TRAIN_SONY,
        TRAIN_RC5,
        TRAIN_NOISE
    } train_kind_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [DUR_W-1:0]     duration_us;
    logic                 out_valid;
    logic                 out_ready;
    logic                 decoded;
    logic [1:0]           protocol;
    logic [15:0]          address;
    logic [15:0]          command;
    logic                 repeat_res;
    logic [PCNT_W-1:0]    pulse_count;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DUR_W-1:0]     cfg_wdata;

    ir_remote_pulse_decoder_top #(
        .FRAME_CAPACITY (FRAME_CAP)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .duration_us (duration_us),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .decoded     (decoded),
        .protocol    (protocol),
        .address     (address),
        .command     (command),
        .repeat_res  (repeat_res),
        .pulse_count (pulse_count),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor copy of the registers and of the frame state
    logic [DUR_W-1:0]  gap_lim;
    logic [MINP_W-1:0] min_len;
    logic [7:0]        frame_len;
    logic [15:0]       held_mark;
    bit                nec_ok;
    bit                sony_ok;
    bit                rc5_ok;
    logic [31:0]       nec_code;
    logic [15:0]       sony_code;
    logic [10:0]       rc5_code;

    // Expected results, oldest first
    irpd_result_t frame_results [$];
    irpd_result_t want_res;

    int fail_count  = 0;
    int sent_items  = 0;
    bit quiet_tail  = 1'b0;

    // Directed table. A count of -1 means the predictor supplies the whole result;
    // otherwise the result is "not decoded" with that pulse count.
    int dir_dur [DIR_ROWS] = '{
        0, 65535, 65536, 1048575, 100000, 100001,
        2800, 400, 1000, 1201, 1400, 401, 1100, 200000,
        8000, 5000, 500, 1601, 700, 501, 600, 1600, 650, 500000,
        700, 1000, 801, 800
    };
    int dir_count [DIR_ROWS] = '{
        1, 2, 3, 0, 1, 0,
        -1, -1, -1, -1, -1, -1, -1, 0,
        -1, -1, -1, -1, -1, -1, -1, -1, -1, 0,
        -1, -1, -1, -1
    };

    function automatic bit in_range(input logic [15:0] v, input int lo, input int hi);
        return (v >= lo) && (v <= hi);
    endfunction

    function automatic void clear_frame();
        frame_len = '0;
        held_mark = '0;
        nec_ok    = 1'b1;
        sony_ok   = 1'b1;
        rc5_ok    = 1'b1;
        nec_code  = '0;
        sony_code = '0;
        rc5_code  = '0;
    endfunction

    // Advance the three checkers by one mark/space pair
    function automatic void update_checkers(input logic [15:0] m, input logic [15:0] s,
                                            input bit header);
        if (header)
        begin
            nec_ok  = nec_ok && in_range(m, 8000, 10000) && in_range(s, 4000, 5000);
            sony_ok = sony_ok && in_range(m, 2000, 2800) && in_range(s, 400, 800);
            rc5_ok  = rc5_ok && in_range(m, 700, 1000) && in_range(s, 700, 1000);
            return;
        end
        if (nec_ok)
        begin
            if (!in_range(m, 500, 700))
                nec_ok = 1'b0;
            else if (s > 1600)
                nec_code = {nec_code[30:0], 1'b1};
            else if (s > 500)
                nec_code = {nec_code[30:0], 1'b0};
            else
                nec_ok = 1'b0;
        end
        if (sony_ok)
        begin
            if (!in_range(m, 1000, 1400))
                sony_ok = 1'b0;
            else if (s > 1200)
                sony_code = {sony_code[14:0], 1'b1};
            else if (s > 400)
                sony_code = {sony_code[14:0], 1'b0};
            else
                sony_ok = 1'b0;
        end
        if (rc5_ok)
        begin
            if (!in_range(m, 700, 1000) || !in_range(s, 700, 1000))
                rc5_ok = 1'b0;
            else
                rc5_code = {rc5_code[9:0], m > 800};
        end
    endfunction

    // Take one accepted duration and return the result it causes
    function automatic irpd_result_t predict_frame_result(input logic [DUR_W-1:0] d);
        irpd_result_t r;
        logic [15:0]  v;
        r = '0;
        if (d > gap_lim)
            clear_frame();
        else if (frame_len < FRAME_CAP)
        begin
            v = (d > 20'h0FFFF) ? 16'hFFFF : d[15:0];
            if (frame_len[0])
                update_checkers(held_mark, v, frame_len == 8'd1);
            else
                held_mark = v;
            frame_len = frame_len + 8'd1;
        end
        if (frame_len >= min_len)
        begin
            if (nec_ok && frame_len >= 68)
            begin
                r.decoded    = 1'b1;
                r.protocol   = PROTO_NEC;
                r.address    = nec_code[31:16];
                r.command    = nec_code[15:0];
                r.repeat_res = (nec_code == 32'hFFFF_FFFF);
            end
            else if (sony_ok && frame_len >= 24)
            begin
                r.decoded  = 1'b1;
                r.protocol = PROTO_SONY;
                r.address  = {8'h00, sony_code[15:8]};
                r.command  = {8'h00, sony_code[7:0]};
            end
            else if (rc5_ok && frame_len >= 28)
            begin
                r.decoded  = 1'b1;
                r.protocol = PROTO_RC5;
                r.address  = {11'h000, rc5_code[10:6]};
                r.command  = {10'h000, rc5_code[5:0]};
            end
        end
        r.pulse_count = frame_len;
        return r;
    endfunction

    // Favour the window edges, otherwise anywhere inside
    function automatic logic [DUR_W-1:0] pick_in(input int lo, input int hi);
        case ($urandom_range(0, 5))
            0:       return DUR_W'(lo);
            1:       return DUR_W'(hi);
            default: return DUR_W'($urandom_range(hi, lo));
        endcase
    endfunction

    // A duration just above the current gap limit, now and then the largest one
    function automatic logic [DUR_W-1:0] gap_duration();
        int unsigned room;
        room = DUR_MAX - gap_lim;
        if ($urandom_range(0, 9) == 0)
            return DUR_MAX;
        if (room > 5000)
            room = 5000;
        return DUR_W'(gap_lim + $urandom_range(room, 1));
    endfunction

    // Offer one duration; record its expected result on transfer
    task automatic push_duration(input logic [DUR_W-1:0] d, input int typed_count);
        irpd_result_t res;
        int           hold;
        if (!quiet_tail && $urandom_range(0, 7) == 0)
        begin
            hold = $urandom_range(1, 17);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (hold - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        duration_us <= d;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        res = predict_frame_result(d);
        if (typed_count >= 0)
        begin
            res             = '0;
            res.pulse_count = typed_count[7:0];
        end
        frame_results.push_back(res);
        sent_items++;
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (frame_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [DUR_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_GAP_LIMIT)
            gap_lim = val;
        else
            min_len = val[MINP_W-1:0];
    endtask

    // Build one pulse train, maybe break it, send it and usually close it with a gap
    task automatic send_train(input train_kind_t kind);
        logic [DUR_W-1:0] pulses [$];
        int               pairs;
        bit               all_ones;
        int               spot;
        pairs    = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 64) : 0;
        all_ones = ($urandom_range(0, 4) == 0);
        case (kind)
            TRAIN_NEC:
            begin
                if (pairs == 0)
                    pairs = $urandom_range(31, 36);
                pulses.push_back(pick_in(8000, 10000));
                pulses.push_back(pick_in(4000, 5000));
                repeat (pairs)
                begin
                    pulses.push_back(pick_in(500, 700));
                    pulses.push_back((all_ones || $urandom_range(0, 1)) ?
                                     pick_in(1601, 2400) : pick_in(501, 1600));
                end
                pulses.push_back(pick_in(500, 700));
            end
            TRAIN_SONY:
            begin
                if (pairs == 0)
                    pairs = $urandom_range(11, 16);
                pulses.push_back(pick_in(2000, 2800));
                pulses.push_back(pick_in(400, 800));
                repeat (pairs)
                begin
                    pulses.push_back(pick_in(1000, 1400));
                    pulses.push_back((all_ones || $urandom_range(0, 1)) ?
                                     pick_in(1201, 1800) : pick_in(401, 1200));
                end
                pulses.push_back(pick_in(1000, 1400));
            end
            TRAIN_RC5:
            begin
                if (pairs == 0)
                    pairs = $urandom_range(13, 16);
                repeat (pairs + 1)
                begin
                    pulses.push_back(all_ones ? pick_in(801, 1000) : pick_in(700, 1000));
                    pulses.push_back(pick_in(700, 1000));
                end
            end
            default:
            begin
                repeat ($urandom_range(1, 40))
                begin
                    case ($urandom_range(0, 3))
                        0:       pulses.push_back(DUR_W'($urandom()));
                        1:       pulses.push_back('0);
                        default: pulses.push_back(DUR_W'($urandom_range(0, 12000)));
                    endcase
                end
            end
        endcase
        if (kind != TRAIN_NOISE && $urandom_range(0, 4) == 0)
        begin
            spot         = $urandom_range(0, pulses.size() - 1);
            pulses[spot] = DUR_W'($urandom_range(0, 12000));
        end
        foreach (pulses[i])
            push_duration(pulses[i], -1);
        // Leave the odd train unterminated so the next one runs on into it
        if (gap_lim != DUR_MAX && $urandom_range(0, 7) != 0)
            push_duration(gap_duration(), -1);
    endtask

    // Retune the registers while idle, then stream random trains
    task automatic run_phase(input logic [DUR_W-1:0] gap, input logic [MINP_W-1:0] minp,
                             input int items, input bit calm_end);
        int target;
        int pick;
        drain_results();
        write_reg(CFG_GAP_LIMIT, gap);
        // Upper bits of the minimum-count write carry junk that must be ignored
        write_reg(CFG_MIN_PULSES, {12'($urandom()), minp});
        target = sent_items + items;
        while (sent_items < target)
        begin
            if (calm_end && sent_items >= target - 150)
                quiet_tail = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick < 3)
                send_train(TRAIN_NEC);
            else if (pick < 6)
                send_train(TRAIN_SONY);
            else if (pick < 8)
                send_train(TRAIN_RC5);
            else
                send_train(TRAIN_NOISE);
        end
    endtask

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, got);
            fail_count++;
        end
    endtask

    // Receiver: stall in random bursts, then run flat out at the tail
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Compare every result transfer against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (frame_results.size() == 0)
            begin
                $display("%0t: result transfer with nothing expected, actual count 0x%0h",
                         $time, pulse_count);
                fail_count++;
            end
            else
            begin
                want_res = frame_results.pop_front();
                check_field("decoded", 32'(want_res.decoded), 32'(decoded));
                check_field("protocol", 32'(want_res.protocol), 32'(protocol));
                check_field("address", 32'(want_res.address), 32'(address));
                check_field("command", 32'(want_res.command), 32'(command));
                check_field("repeat_res", 32'(want_res.repeat_res), 32'(repeat_res));
                check_field("pulse_count", 32'(want_res.pulse_count), 32'(pulse_count));
            end
        end
    end

    // Watchdog: generous bound on the slowest legal run
    initial
    begin
        #(5_000_000);
        $display("** ir_remote_pulse_decoder_top: FAILED **");
        $finish;
    end

    initial
    begin
        in_valid    = 1'b0;
        duration_us = '0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_GAP_LIMIT;
        cfg_wdata   = '0;
        rst_n       = 1'b0;
        gap_lim     = 20'd100000;
        min_len     = 8'd10;
        clear_frame();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, saturation, gap on and above the limit,
        // short header-plus-data runs separated by gaps, the first two ending in a mark
        for (int i = 0; i < DIR_ROWS; i++)
            push_duration(DUR_W'(dir_dur[i]), dir_count[i]);

        // Reset settings written back explicitly, then the extremes and a few in between
        run_phase(20'd100000, 8'd10, 600, 1'b0);
        run_phase(DUR_MAX, 8'd0, 200, 1'b0);
        run_phase(20'd0, 8'd255, 100, 1'b0);
        run_phase(20'd20000, 8'd24, 500, 1'b0);
        run_phase(20'd9500, 8'd68, 400, 1'b1);

        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("** ir_remote_pulse_decoder_top: PASSED **");
        else
            $display("** ir_remote_pulse_decoder_top: FAILED **");
        $finish;
    end

endmodule
